FILE: rtl/p2a_pkg.sv
`default_nettype none

package p2a_pkg;

  // Input word: one RGB pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Output word: one byte of the terminal sequence
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } res_t;

  // Classified pixel, as held in the queue between front and back
  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic       has3;
    logic [7:0] glyph;
  } ent_t;

  localparam int unsigned P2A_QUEUE_DEPTH = 2;

  // Rec.709 luma weights in Q0.16
  localparam int unsigned P2A_W_RED   = 13933;
  localparam int unsigned P2A_W_GREEN = 46871;
  localparam int unsigned P2A_W_BLUE  = 4732;
  localparam int unsigned P2A_RAMP_LEN = 68;
  // Reciprocal of 255 for 16-bit dividends: (x * 32897) >> 23
  localparam int unsigned P2A_RECIP_255 = 32897;
  localparam int unsigned P2A_RECIP_SHIFT = 23;

  localparam logic [7:0] P2A_ESC    = 8'h1B;
  localparam logic [7:0] P2A_ZERO   = 8'h30;
  localparam logic [7:0] P2A_M      = 8'h6D;
  localparam logic [7:0] P2A_LBRACK = 8'h5B;

  // Byte positions within one pixel's sequence (three-digit layout)
  localparam logic [4:0] P2A_POS_LEAD_END = 5'd17;
  localparam logic [4:0] P2A_POS_HUND     = 5'd18;
  localparam logic [4:0] P2A_POS_TENS     = 5'd19;
  localparam logic [4:0] P2A_POS_ONES     = 5'd20;
  localparam logic [4:0] P2A_POS_M        = 5'd21;
  localparam logic [4:0] P2A_POS_GLYPH    = 5'd22;
  localparam logic [4:0] P2A_POS_TESC     = 5'd23;
  localparam logic [4:0] P2A_POS_TBRACK   = 5'd24;
  localparam logic [4:0] P2A_POS_TZERO    = 5'd25;
  localparam logic [4:0] P2A_POS_LAST     = 5'd26;

  localparam logic [17*8-1:0] P2A_LEAD = "[1;48;5;232;38;5;";

  localparam logic [68*8-1:0] P2A_RAMP =
    "   `^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

  // Brightness ramp character for an index of 0..67
  function automatic logic [7:0] p2a_ramp(input logic [6:0] idx);
    logic [7:0] ch;
    ch = 8'h20;
    for (int i = 0; i < 68; i++) begin
      if (idx == 7'(i)) begin
        ch = P2A_RAMP[(67 - i)*8 +: 8];
      end
    end
    return ch;
  endfunction

  // Byte at a given position of the sequence for a classified pixel
  function automatic logic [7:0] p2a_byte(input logic [4:0] pos, input ent_t ent);
    logic [7:0] b;
    b = P2A_ESC;
    if (pos == 5'd0) begin
      b = P2A_ESC;
    end else if (pos <= P2A_POS_LEAD_END) begin
      for (int j = 0; j < 17; j++) begin
        if (pos == 5'(j + 1)) begin
          b = P2A_LEAD[(16 - j)*8 +: 8];
        end
      end
    end else begin
      case (pos)
        P2A_POS_HUND:   b = P2A_ZERO + {6'd0, ent.hund};
        P2A_POS_TENS:   b = P2A_ZERO + {4'd0, ent.tens};
        P2A_POS_ONES:   b = P2A_ZERO + {4'd0, ent.ones};
        P2A_POS_M:      b = P2A_M;
        P2A_POS_GLYPH:  b = ent.glyph;
        P2A_POS_TESC:   b = P2A_ESC;
        P2A_POS_TBRACK: b = P2A_LBRACK;
        P2A_POS_TZERO:  b = P2A_ZERO;
        P2A_POS_LAST:   b = P2A_M;
        default:        b = P2A_ESC;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/p2a_front.sv
`default_nettype none

module p2a_front import p2a_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire pix_t in_data_i,
  output logic      push_valid_o,
  input  wire logic push_ready_i,
  output ent_t      push_data_o
);

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  logic [23:0] y16_q, y16_d;
  logic [7:0]  code_q, code_d;
  logic [14:0] q_q, q_d;
  logic [1:0]  hund_q, hund_d;
  logic [3:0]  tens_q, tens_d;
  logic [3:0]  ones_q, ones_d;
  logic        has3_q, has3_d;
  ent_t        ent_q, ent_d;
  logic [2:0]  lvl_r, lvl_g, lvl_b;
  logic [30:0] t68;
  logic [30:0] recip;
  logic [7:0]  idx_raw;
  logic [6:0]  idx;
  logic [7:0]  rem;

  // Colour cube level: floor(5c/255) equals floor(c/51)
  function automatic logic [2:0] lvl6(input logic [7:0] c);
    logic [2:0] l;
    if (c >= 8'd255)      l = 3'd5;
    else if (c >= 8'd204) l = 3'd4;
    else if (c >= 8'd153) l = 3'd3;
    else if (c >= 8'd102) l = 3'd2;
    else if (c >= 8'd51)  l = 3'd1;
    else                  l = 3'd0;
    return l;
  endfunction

  // Stall chain: each stage moves when the one after it can take its word
  assign rdy3 = !v3_q || push_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: luma sum and colour code
  always_comb begin
    lvl_r  = lvl6(in_data_i.red);
    lvl_g  = lvl6(in_data_i.green);
    lvl_b  = lvl6(in_data_i.blue);
    code_d = 8'(16 + 36 * int'(lvl_r) + 6 * int'(lvl_g) + int'(lvl_b));
    y16_d  = 24'(32'(in_data_i.red) * P2A_W_RED
                + 32'(in_data_i.green) * P2A_W_GREEN
                + 32'(in_data_i.blue) * P2A_W_BLUE);
  end

  // Stage 2: scale luma by the ramp length, split code into digits
  always_comb begin
    t68  = {1'b0, y16_q, 6'd0} + {5'd0, y16_q, 2'd0};
    q_d  = t68[30:16];
    if (code_q >= 8'd200) begin
      hund_d = 2'd2;
      rem    = code_q - 8'd200;
    end else if (code_q >= 8'd100) begin
      hund_d = 2'd1;
      rem    = code_q - 8'd100;
    end else begin
      hund_d = 2'd0;
      rem    = code_q;
    end
    has3_d = code_q >= 8'd100;
    tens_d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(10 * k)) tens_d = 4'(k);
    end
    ones_d = 4'(rem - 8'(10 * int'(tens_d)));
  end

  // Stage 3: divide by 255 through the reciprocal, clamp, pick the glyph
  always_comb begin
    recip   = 31'(32'(q_q) * P2A_RECIP_255);
    idx_raw = recip[30:P2A_RECIP_SHIFT];
    idx     = (idx_raw > 8'(P2A_RAMP_LEN - 1)) ? 7'(P2A_RAMP_LEN - 1) : idx_raw[6:0];
    ent_d.hund  = hund_q;
    ent_d.tens  = tens_q;
    ent_d.ones  = ones_q;
    ent_d.has3  = has3_q;
    ent_d.glyph = p2a_ramp(idx);
  end

  // Hold valid bits per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      y16_q  <= y16_d;
      code_q <= code_d;
    end
    if (rdy2) begin
      q_q    <= q_d;
      hund_q <= hund_d;
      tens_q <= tens_d;
      ones_q <= ones_d;
      has3_q <= has3_d;
    end
    if (rdy3) begin
      ent_q <= ent_d;
    end
  end

  assign push_valid_o = v3_q;
  assign push_data_o  = ent_q;

endmodule

`default_nettype wire

FILE: rtl/p2a_queue.sv
`default_nettype none

module p2a_queue import p2a_pkg::*; #(
  parameter int unsigned Depth = P2A_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire ent_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output ent_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ent_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/p2a_back.sv
`default_nettype none

module p2a_back import p2a_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic head_valid_i,
  output logic      head_pop_o,
  input  wire ent_t head_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic [4:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  res_t       out_q, out_d;
  logic       load;

  // Emit a byte of the head pixel whenever one is queued and the output register is free or being taken
  assign load = head_valid_i && (!out_valid_q || out_ready_i);
  assign head_pop_o = load && (pos_q == P2A_POS_LAST);

  always_comb begin
    pos_d          = pos_q;
    out_valid_d    = out_valid_q;
    out_d.out_byte = p2a_byte(pos_q, head_data_i);
    out_d.last_byte = pos_q == P2A_POS_LAST;
    if (out_ready_i) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      // Skip the hundreds digit for two-digit codes
      if (pos_q == P2A_POS_LAST)
        pos_d = '0;
      else if (pos_q == P2A_POS_LEAD_END && !head_data_i.has3)
        pos_d = P2A_POS_TENS;
      else
        pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/pixel_to_ansi_ascii_encoder_unit.sv
`default_nettype none

// Turns each RGB pixel into a coloured terminal glyph: the bytes
// ESC[1;48;5;232;38;5;<code>m<char>ESC[0m, where <code> is the xterm-256
// colour cube entry 16+36r'+6g'+b' (c' = floor(5c/255)) in decimal and <char>
// comes from a 68-step brightness ramp indexed by Rec.709 luma, clamped at
// white. One pixel yields 26 bytes (two-digit code) or 27 bytes (three-digit
// code); last_byte marks the final one. The byte sequencer sends one byte per
// cycle while out_ready_i is high, and the next pixel's bytes follow the
// previous one's with no gap when that pixel is already queued. A three-stage
// classifier feeds a small queue (QueueDepth words) ahead of the sequencer,
// so pixels are taken while bytes of earlier ones are still going out; a pixel
// passes the classifier stages, the queue and the output register in turn.
module pixel_to_ansi_ascii_encoder_unit import p2a_pkg::*; #(
  parameter int unsigned QueueDepth = P2A_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire pix_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic push_valid, push_ready;
  ent_t push_data;
  logic head_valid, head_pop;
  ent_t head_data;

  // Classify pixels
  p2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Decouple classifier from sequencer
  p2a_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (head_valid),
    .pop_ready_i (head_pop),
    .pop_data_o  (head_data)
  );

  // Send the bytes
  p2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_pop_o  (head_pop),
    .head_data_i (head_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/pixel_to_ansi_ascii_encoder_unit_test.sv
`timescale 1ns / 1ps

module pixel_to_ansi_ascii_encoder_unit_test;
  import p2a_pkg::*;

  localparam int unsigned CyclesLimit   = 2_000_000;
  localparam int unsigned RandomPixels  = 340;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAfter  = 40;
  localparam int unsigned DrainCycles   = 40;

  localparam logic [7:0] EscChar     = 8'h1B;
  localparam logic [7:0] DigitZero   = 8'h30;
  localparam logic [7:0] SgrEnd      = 8'h6D;
  localparam logic [7:0] OpenBracket = 8'h5B;

  localparam longint unsigned LumaRed   = 13933;
  localparam longint unsigned LumaGreen = 46871;
  localparam longint unsigned LumaBlue  = 4732;
  localparam longint unsigned LumaOne   = 65536;
  localparam longint unsigned RampSteps = 68;
  localparam longint unsigned ChanFull  = 255;

  localparam logic [17*8-1:0] SgrLead = "[1;48;5;232;38;5;";
  localparam logic [68*8-1:0] GlyphRamp =
    "   `^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

  // Expected byte stream for every accepted pixel, checked in order
  class ansi_glyph_board;
    res_t pending_bytes[$];
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned short_codes;
    int unsigned long_codes;
    int unsigned clamped_whites;

    function new();
      mismatches     = 0;
      bytes_checked  = 0;
      short_codes    = 0;
      long_codes     = 0;
      clamped_whites = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic fin);
      res_t w;
      w.out_byte  = b;
      w.last_byte = fin;
      pending_bytes.push_back(w);
    endfunction

    function int unsigned cube_level(logic [7:0] c);
      return (5 * int'(c)) / 255;
    endfunction

    // Build the full sequence for one pixel
    function void note_pixel(pix_t px);
      int unsigned code;
      longint unsigned luma;
      longint unsigned step;
      code = 16 + 36 * cube_level(px.red) + 6 * cube_level(px.green)
           + cube_level(px.blue);
      luma = LumaRed * longint'(px.red) + LumaGreen * longint'(px.green)
           + LumaBlue * longint'(px.blue);
      step = (RampSteps * luma) / (ChanFull * LumaOne);
      // white reaches one past the end of the ramp: hold at the last glyph
      if (step > RampSteps - 1) begin
        step = RampSteps - 1;
        clamped_whites++;
      end
      push_byte(EscChar, 1'b0);
      for (int j = 0; j < 17; j++) begin
        push_byte(SgrLead[(16 - j)*8 +: 8], 1'b0);
      end
      if (code >= 100) begin
        push_byte(DigitZero + 8'(code / 100), 1'b0);
        push_byte(DigitZero + 8'((code / 10) % 10), 1'b0);
        long_codes++;
      end else begin
        push_byte(DigitZero + 8'(code / 10), 1'b0);
        short_codes++;
      end
      push_byte(DigitZero + 8'(code % 10), 1'b0);
      push_byte(SgrEnd, 1'b0);
      push_byte(GlyphRamp[(67 - int'(step))*8 +: 8], 1'b0);
      push_byte(EscChar, 1'b0);
      push_byte(OpenBracket, 1'b0);
      push_byte(DigitZero, 1'b0);
      push_byte(SgrEnd, 1'b1);
    endfunction

    // Compare one delivered word with the oldest expected byte
    function void check_byte(res_t got);
      res_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected word: out_byte 0x%02h last_byte %0b",
               got.out_byte, got.last_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
          mismatches++;
        end
        if (got.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  pix_t in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  res_t out_data_o;

  ansi_glyph_board glyph_board = new();

  logic        calm_phase     = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned pixels_taken   = 0;
  int unsigned hold_left      = 0;
  int unsigned ready_roll     = 0;
  int unsigned cycle_count    = 0;

  logic [7:0] cube_edges [11] = '{8'd0, 8'd50, 8'd51, 8'd101, 8'd102, 8'd152,
                                  8'd153, 8'd203, 8'd204, 8'd254, 8'd255};

  pixel_to_ansi_ascii_encoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CyclesLimit) begin
      $display("pixel_to_ansi_ascii_encoder_unit_test: errors");
      $finish;
    end
  end

  // Take output words, with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      glyph_board.check_byte(out_data_o);
    end
    if (!long_hold_done && pixels_taken >= HoldOffAfter) begin
      long_hold_done = 1'b1;
      hold_left = HoldOffCycles;
    end else if (hold_left == 0 && !calm_phase) begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll >= 95) begin
        hold_left = $urandom_range(10, 60);
      end else if (ready_roll >= 70) begin
        hold_left = $urandom_range(1, 3);
      end
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_phase) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Mostly uniform channels, some on the colour cube thresholds
  function automatic logic [7:0] random_channel();
    if ($urandom_range(0, 9) < 6) begin
      return 8'($urandom_range(0, 255));
    end
    return cube_edges[$urandom_range(0, 10)];
  endfunction

  // Offer one pixel and hold it until taken
  task automatic send_pixel(input pix_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    glyph_board.note_pixel(px);
    pixels_taken++;
  endtask

  initial begin
    pix_t px;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners, channel steps and the two/three digit boundary
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd254, 8'd254, 8'd254});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    send_pixel('{8'd102, 8'd51, 8'd255});
    send_pixel('{8'd102, 8'd102, 8'd0});
    send_pixel('{8'd50, 8'd50, 8'd50});
    send_pixel('{8'd51, 8'd51, 8'd51});
    send_pixel('{8'd203, 8'd204, 8'd153});
    send_pixel('{8'd0, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd255, 8'd0});
    send_pixel('{8'd170, 8'd85, 8'd170});
    send_pixel('{8'd85, 8'd170, 8'd85});
    send_pixel('{8'd1, 8'd2, 8'd4});
    send_pixel('{8'd128, 8'd128, 8'd128});
    send_pixel('{8'd255, 8'd255, 8'd254});

    // Random pixels, with a stretch of back-to-back traffic
    for (int n = 0; n < RandomPixels; n++) begin
      calm_phase = (n >= 150 && n < 210);
      px.red   = random_channel();
      px.green = random_channel();
      px.blue  = random_channel();
      send_pixel(px);
    end
    calm_phase = 1'b0;
    in_valid_i <= 1'b0;

    // Drain and let the pipeline settle
    while (glyph_board.pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d pixels: %0d two-digit and %0d three-digit codes, %0d white clamps",
             pixels_taken, glyph_board.short_codes, glyph_board.long_codes,
             glyph_board.clamped_whites);
    $display("%0d bytes checked, one %0d-cycle output hold with the input backed up",
             glyph_board.bytes_checked, HoldOffCycles);
    if (glyph_board.mismatches == 0 && glyph_board.pending_bytes.size() == 0) begin
      $display("pixel_to_ansi_ascii_encoder_unit_test: clean");
    end else begin
      $display("pixel_to_ansi_ascii_encoder_unit_test: errors");
    end
    $finish;
  end

endmodule
